### hdl/qapm_pkg.sv
// Shared types, constants and codes for the attitude PID and motor mixer.
`timescale 1ns / 1ps
`default_nettype none

package qapm_pkg;

    // floor(x / 1000) for any 16-bit x equals (x * 67109) >> 26
    localparam int DT_RECIP  = 67109;
    localparam int DT_SHIFT  = 26;
    localparam int DT_W      = 7;
    localparam int ELAPSED_W = 16;

    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int SUM_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 12;

    localparam int MUL_A_W  = 49;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 58;
    localparam int FRAC_W   = 16;
    localparam int DRIVE_W  = ACC_W - FRAC_W;
    localparam int MIX_W    = DRIVE_W + 1;

    localparam int DIV_W    = 34;
    localparam int QUO_W    = DIV_W + 1;
    localparam int DIV_CNT_W = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_WINDOW       = 3'd3,
        REG_MIN_THROTTLE = 3'd4,
        REG_MAX_THROTTLE = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DT_MUL,
        OP_DT_SET,
        OP_ERR,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_IDT,
        OP_MUL_D,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ACC_D,
        OP_MIX
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic signed [15:0] roll_target;
        logic signed [15:0] roll_measured;
        logic signed [15:0] pitch_target;
        logic signed [15:0] pitch_measured;
        logic [THR_W-1:0]   throttle;
        logic [15:0]        time_us;
    } in_item_t;

    typedef struct packed {
        logic [THR_W-1:0] motor_zero;
        logic [THR_W-1:0] motor_one;
        logic [THR_W-1:0] motor_two;
        logic [THR_W-1:0] motor_three;
    } out_item_t;

endpackage

`default_nettype wire

### hdl/qapm_if.sv
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface qapm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_target;
    logic signed [15:0] roll_measured;
    logic signed [15:0] pitch_target;
    logic signed [15:0] pitch_measured;
    logic [11:0]        throttle;
    logic [15:0]        time_us;

    modport source (output valid, roll_target, roll_measured, pitch_target,
                    pitch_measured, throttle, time_us, input ready);
    modport sink   (input valid, roll_target, roll_measured, pitch_target,
                    pitch_measured, throttle, time_us, output ready);
endinterface

interface qapm_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] motor_zero;
    logic [11:0] motor_one;
    logic [11:0] motor_two;
    logic [11:0] motor_three;

    modport source (output valid, motor_zero, motor_one, motor_two, motor_three,
                    input ready);
    modport sink   (input valid, motor_zero, motor_one, motor_two, motor_three,
                    output ready);
endinterface

interface qapm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/qapm_dpath.sv
// Datapath: configuration registers, loop state, shared multiplier and serial divider.
`timescale 1ns / 1ps
`default_nettype none

module qapm_dpath
    import qapm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    qapm_cfg_if.sink        cfg,
    input  wire in_item_t   in_item,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    output out_item_t       out_item
);

    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, window_reg;
    logic [THR_W-1:0]  min_thr_reg, max_thr_reg;

    logic [ELAPSED_W-1:0]    last_time_reg, elapsed_reg;
    logic [DT_W-1:0]         dt_reg;
    logic signed [ERR_W-1:0] prev_reg [2];
    logic signed [SUM_W-1:0] sum_reg  [2];
    logic [DIV_CNT_W-1:0]    cnt_reg;

    in_item_t                 item_reg;
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DRIVE_W-1:0] drive_reg [2];
    logic [DIV_W-1:0]         dvd_reg;
    logic [DT_W-1:0]          rem_reg;
    logic                     neg_reg;
    out_item_t                out_reg;

    logic signed [ERR_W-1:0]   e_cur;
    logic [ERR_W-1:0]          mag;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [DT_W-1:0]           dt_raw;
    logic [PROD_W-1:0]         prod_abs;
    logic [DT_W+1:0]           trial;
    logic signed [QUO_W-1:0]   quo;
    logic signed [ACC_W-1:0]   total;

    function automatic logic [THR_W-1:0] mix(
        input logic [THR_W-1:0]          thr,
        input logic signed [DRIVE_W-1:0] drv,
        input logic                      sub,
        input logic [THR_W-1:0]          lo,
        input logic [THR_W-1:0]          hi
    );
        logic signed [MIX_W-1:0] v;
        logic signed [MIX_W-1:0] base;
        base = $signed({{(MIX_W-THR_W){1'b0}}, thr});
        v = sub ? base - MIX_W'(drv) : base + MIX_W'(drv);
        if (v < $signed({{(MIX_W-THR_W){1'b0}}, lo}))
            return lo;
        else if (v > $signed({{(MIX_W-THR_W){1'b0}}, hi}))
            return hi;
        else
            return v[THR_W-1:0];
    endfunction

    assign cfg.ready       = 1'b1;
    assign status.div_done = (cnt_reg == '0);
    assign out_item        = out_reg;

    // error of the selected axis, taken from the held item
    always_comb
    begin
        if (cmd.axis)
            e_cur = $signed({item_reg.pitch_target[15], item_reg.pitch_target})
                  - $signed({item_reg.pitch_measured[15], item_reg.pitch_measured});
        else
            e_cur = $signed({item_reg.roll_target[15], item_reg.roll_target})
                  - $signed({item_reg.roll_measured[15], item_reg.roll_measured});
        mag      = e_cur[ERR_W-1] ? ERR_W'(-e_cur) : ERR_W'(e_cur);
        sum_wide = $signed({sum_reg[cmd.axis][SUM_W-1], sum_reg[cmd.axis]})
                 + $signed({{(SUM_W+1-ERR_W){e_cur[ERR_W-1]}}, e_cur});
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_DT_MUL:
            begin
                mul_a = $signed({{(MUL_A_W-ELAPSED_W){1'b0}}, elapsed_reg});
                mul_b = MUL_B_W'(DT_RECIP);
            end
            OP_MUL_P:
            begin
                mul_a = $signed({{(MUL_A_W-ERR_W){e_reg[ERR_W-1]}}, e_reg});
                mul_b = $signed({2'b00, gain_p_reg});
            end
            OP_MUL_I:
            begin
                mul_a = $signed({{(MUL_A_W-SUM_W){sum_reg[cmd.axis][SUM_W-1]}},
                                 sum_reg[cmd.axis]});
                mul_b = $signed({2'b00, gain_i_reg});
            end
            OP_MUL_IDT:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_reg});
            end
            OP_MUL_D:
            begin
                mul_a = $signed({{(MUL_A_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg});
                mul_b = $signed({2'b00, gain_d_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign dt_raw   = prod_reg[DT_SHIFT+DT_W-1:DT_SHIFT];
    assign prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign trial    = {1'b0, rem_reg, dvd_reg[DIV_W-1]} - {2'b00, dt_reg};
    assign quo      = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign total    = acc_reg + $signed({{(ACC_W-QUO_W){quo[QUO_W-1]}}, quo});

    // configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= GAIN_W'(256);
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            window_reg    <= GAIN_W'(384);
            min_thr_reg   <= THR_W'(1000);
            max_thr_reg   <= THR_W'(2000);
            last_time_reg <= '0;
            prev_reg[0]   <= '0;
            prev_reg[1]   <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_GAIN_P:       gain_p_reg  <= cfg.data;
                    REG_GAIN_I:       gain_i_reg  <= cfg.data;
                    REG_GAIN_D:       gain_d_reg  <= cfg.data;
                    REG_WINDOW:       window_reg  <= cfg.data;
                    REG_MIN_THROTTLE: min_thr_reg <= cfg.data[THR_W-1:0];
                    REG_MAX_THROTTLE: max_thr_reg <= cfg.data[THR_W-1:0];
                    default:          ;
                endcase
            end
            case (cmd.op)
                OP_LOAD:
                    last_time_reg <= in_item.time_us;
                OP_ERR:
                begin
                    prev_reg[cmd.axis] <= e_cur;
                    if (mag < {1'b0, window_reg})
                        sum_reg[cmd.axis] <= sum_sat;
                end
                OP_DIV_START:
                    cnt_reg <= DIV_CNT_W'(DIV_W);
                OP_DIV_STEP:
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - 1'b1;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                item_reg    <= in_item;
                elapsed_reg <= in_item.time_us - last_time_reg;
            end
            OP_DT_MUL:
                prod_reg <= mul_p;
            OP_DT_SET:
                dt_reg <= (dt_raw == '0) ? DT_W'(1) : dt_raw;
            OP_ERR:
            begin
                e_reg    <= e_cur;
                diff_reg <= $signed({e_cur[ERR_W-1], e_cur})
                          - $signed({prev_reg[cmd.axis][ERR_W-1], prev_reg[cmd.axis]});
            end
            OP_MUL_P:
                prod_reg <= mul_p;
            OP_MUL_I:
            begin
                acc_reg  <= prod_reg[ACC_W-1:0];
                prod_reg <= mul_p;
            end
            OP_MUL_IDT:
                prod_reg <= mul_p;
            OP_MUL_D:
            begin
                acc_reg  <= acc_reg + prod_reg[ACC_W-1:0];
                prod_reg <= mul_p;
            end
            OP_DIV_START:
            begin
                neg_reg <= prod_reg[PROD_W-1];
                dvd_reg <= prod_abs[DIV_W-1:0];
                rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (cnt_reg != '0)
                begin
                    if (!trial[DT_W+1])
                    begin
                        rem_reg <= trial[DT_W-1:0];
                        dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[DT_W-2:0], dvd_reg[DIV_W-1]};
                        dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                    end
                end
            end
            OP_ACC_D:
                drive_reg[cmd.axis] <= total[ACC_W-1:FRAC_W];
            OP_MIX:
            begin
                out_reg.motor_zero  <= mix(item_reg.throttle, drive_reg[0], 1'b1,
                                           min_thr_reg, max_thr_reg);
                out_reg.motor_one   <= mix(item_reg.throttle, drive_reg[0], 1'b0,
                                           min_thr_reg, max_thr_reg);
                out_reg.motor_two   <= mix(item_reg.throttle, drive_reg[1], 1'b1,
                                           min_thr_reg, max_thr_reg);
                out_reg.motor_three <= mix(item_reg.throttle, drive_reg[1], 1'b0,
                                           min_thr_reg, max_thr_reg);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hdl/qapm_ctrl.sv
// Controller: sequences the datapath through one item and owns the input and output handshakes.
`timescale 1ns / 1ps
`default_nettype none

module qapm_ctrl
    import qapm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DT_MUL,
        S_DT_SET,
        S_ERR,
        S_MUL_P,
        S_MUL_I,
        S_MUL_IDT,
        S_MUL_D,
        S_DIV_START,
        S_DIV,
        S_ACC_D,
        S_MIX
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.axis       = axis_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = 1'b0;
                    state_next = S_DT_MUL;
                end
            S_DT_MUL:
            begin
                cmd.op     = OP_DT_MUL;
                state_next = S_DT_SET;
            end
            S_DT_SET:
            begin
                cmd.op     = OP_DT_SET;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                cmd.op     = OP_MUL_P;
                state_next = S_MUL_I;
            end
            S_MUL_I:
            begin
                cmd.op     = OP_MUL_I;
                state_next = S_MUL_IDT;
            end
            S_MUL_IDT:
            begin
                cmd.op     = OP_MUL_IDT;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.op     = OP_MUL_D;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_done)
                    state_next = S_ACC_D;
            end
            S_ACC_D:
            begin
                cmd.op = OP_ACC_D;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = S_ERR;
                end
                else
                    state_next = S_MIX;
            end
            S_MIX:
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.op         = OP_MIX;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/quad_attitude_pid_mixer_unit.sv
// Top level of the roll/pitch PID controller with four-motor mixing.
// From input transfer to result valid: the period steps, then per axis the error,
//   multiplies, serial divider and accumulate, then the mix once the output is free.
// A new item is accepted only when the previous one has been mixed and the unit is idle.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) restores default gains and clears loop state.
`timescale 1ns / 1ps
`default_nettype none

module quad_attitude_pid_mixer_unit
    import qapm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    qapm_in_if.sink   in_ch,
    qapm_out_if.source out_ch,
    qapm_cfg_if.sink  cfg_ch
);

    dp_cmd_t    cmd;
    dp_status_t status;
    in_item_t   in_item;
    out_item_t  out_item;

    // gather the input transfer payload
    assign in_item.roll_target    = in_ch.roll_target;
    assign in_item.roll_measured  = in_ch.roll_measured;
    assign in_item.pitch_target   = in_ch.pitch_target;
    assign in_item.pitch_measured = in_ch.pitch_measured;
    assign in_item.throttle       = in_ch.throttle;
    assign in_item.time_us        = in_ch.time_us;

    // sequencer: accepts a transfer, steps the datapath, presents the result
    qapm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic, loop state and configuration registers
    qapm_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

    // the output register holds until the result transfer completes
    assign out_ch.motor_zero  = out_item.motor_zero;
    assign out_ch.motor_one   = out_item.motor_one;
    assign out_ch.motor_two   = out_item.motor_two;
    assign out_ch.motor_three = out_item.motor_three;

endmodule

`default_nettype wire
